/* src/zstp_pkg.sv */
// Shared types and constants for the zoomed sprite tile placement unit.
`default_nettype none
package zstp_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OFF_X   = 3'd0,
    REG_OFF_Y   = 3'd1,
    REG_SMALL   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_MASK    = 3'd5
  } cfg_reg_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ORGX  = 7'b0000010,
    ST_ORGY  = 7'b0000100,
    ST_ROW   = 7'b0001000,
    ST_COL0  = 7'b0010000,
    ST_COL1  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    DIV_ORGX = 3'd0,
    DIV_ORGY = 3'd1,
    DIV_Y0   = 3'd2,
    DIV_Y1   = 3'd3,
    DIV_X0   = 3'd4,
    DIV_X1   = 3'd5
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     take;
    logic     col_next;
    logic     row_next;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic zero_scale;
    logic div_done;
    logic last_col;
    logic last_row;
    logic out_busy;
  } sts_t;

  localparam logic [7:0] ColTable [8] = '{8'd0, 8'd1, 8'd4, 8'd5, 8'd16, 8'd17, 8'd20, 8'd21};
  localparam logic [7:0] RowTable [8] = '{8'd0, 8'd2, 8'd8, 8'd10, 8'd32, 8'd34, 8'd40, 8'd42};

endpackage
`default_nettype wire

/* src/zoomed_sprite_tile_placement_unit.sv */
// Top level of the zoomed sprite tile placement unit.
//  channel | direction | handshake
//  s_axis  | in        | tvalid/tready, tdata = sprite attribute word
//  m_axis  | out       | tvalid/tready, tdata = sub-tile, tlast = last_tile
//  cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i
// All divisions run on the one shared radix-2 divider.
// A zero-scale sprite is taken in idle and yields no output.
// Reset clears the controller and output valid; registers return to defaults.
// Output stalls hold the controller in its emit step.
`default_nettype none
module zoomed_sprite_tile_placement_unit #(
  parameter int unsigned MAX_TILES_PER_SIDE = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // attribute_word, tile_code, pos_y, pos_x, scale_y, scale_x, color, pad
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_tile, screen_x, screen_y, draw_width, draw_height, mirror_x,
  // mirror_y, palette_base, pad
  output logic [87:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  logic signed [15:0] off_x_q, off_y_q;
  logic               small_q;
  logic signed [10:0] shift_x_q, shift_y_q;
  logic [15:0]        mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0; off_y_q <= '0; small_q <= 1'b0;
      shift_x_q <= '0; shift_y_q <= '0; mask_q <= 16'hffff;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zstp_pkg::REG_OFF_X:   off_x_q   <= cfg_data_i;
        zstp_pkg::REG_OFF_Y:   off_y_q   <= cfg_data_i;
        zstp_pkg::REG_SMALL:   small_q   <= cfg_data_i[0];
        zstp_pkg::REG_SHIFT_X: shift_x_q <= cfg_data_i[10:0];
        zstp_pkg::REG_SHIFT_Y: shift_y_q <= cfg_data_i[10:0];
        zstp_pkg::REG_MASK:    mask_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  zstp_pkg::cmd_t cmd;
  zstp_pkg::sts_t sts;

  zstp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  zstp_datapath #(.MaxTiles(MAX_TILES_PER_SIDE)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .attribute_word_i(s_axis_tdata[15:0]),
    .tile_code_i     (s_axis_tdata[31:16]),
    .pos_y_i         (s_axis_tdata[41:32]),
    .pos_x_i         (s_axis_tdata[51:42]),
    .scale_y_i       (s_axis_tdata[59:52]),
    .scale_x_i       (s_axis_tdata[67:60]),
    .color_i         (s_axis_tdata[83:68]),
    .off_x_i         (off_x_q),
    .off_y_i         (off_y_q),
    .small_i         (small_q),
    .shift_x_i       (shift_x_q),
    .shift_y_i       (shift_y_q),
    .mask_i          (mask_q),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_o        (m_axis_tdata),
    .m_last_o        (m_axis_tlast)
  );

  logic unused;
  assign unused = ^s_axis_tdata[87:84];
endmodule
`default_nettype wire

/* src/zstp_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module zstp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [17:0] num_i,
  input  logic [8:0]  den_i,
  output logic        done_o,
  output logic [17:0] quot_o
);
  logic [17:0] quot_q, quot_d;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [9:0]  sh;

  // done stays high with the quotient held until the next start
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    sh     = {rem_q, quot_q[17]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = 5'd18;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d  = 9'(sh - {1'b0, den_q});
        quot_d = {quot_q[16:0], 1'b1};
      end else begin
        rem_d  = sh[8:0];
        quot_d = {quot_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

/* src/zstp_datapath.sv */
// Datapath: sprite decode, origin, edge divisions and output register.
`default_nettype none
module zstp_datapath #(
  parameter int unsigned MaxTiles = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  zstp_pkg::cmd_t        cmd_i,
  output zstp_pkg::sts_t        sts_o,
  input  logic [15:0]           attribute_word_i,
  input  logic [15:0]           tile_code_i,
  input  logic [9:0]            pos_y_i,
  input  logic [9:0]            pos_x_i,
  input  logic [7:0]            scale_y_i,
  input  logic [7:0]            scale_x_i,
  input  logic [15:0]           color_i,
  input  logic signed [15:0]    off_x_i,
  input  logic signed [15:0]    off_y_i,
  input  logic                  small_i,
  input  logic signed [10:0]    shift_x_i,
  input  logic signed [10:0]    shift_y_i,
  input  logic [15:0]           mask_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [87:0]           m_data_o,
  output logic                  m_last_o
);
  logic [15:0] attr_q, code_q, color_q;
  logic [9:0]  px_q, py_q;
  logic [7:0]  sx_q, sy_q;
  logic [3:0]  w_q, h_q;
  logic [2:0]  x_q, y_q;
  logic signed [15:0] ox_q, oy_q, y0_q, y1_q, x0_q;
  logic        dstart;
  logic [17:0] dnum, dq;
  logic [8:0]  dden;
  logic        ddone;

  logic [3:0] w_c, h_c;
  logic [7:0] sx_c;
  always_comb begin
    w_c  = 4'd1 << attribute_word_i[9:8];
    h_c  = 4'd1 << attribute_word_i[11:10];
    if (w_c > 4'(MaxTiles)) w_c = 4'(MaxTiles);
    if (h_c > 4'(MaxTiles)) h_c = 4'(MaxTiles);
    sx_c = attribute_word_i[14] ? scale_y_i : scale_x_i;
  end

  assign sts_o.zero_scale = (scale_y_i == 8'd0) || (sx_c == 8'd0);
  assign sts_o.div_done   = ddone;
  assign sts_o.last_col   = ({1'b0, x_q} == w_q - 4'd1);
  assign sts_o.last_row   = ({1'b0, y_q} == h_q - 4'd1);

  // numerators: 512*n for origin, 2048*k + s for edges; divisor s or 2s
  always_comb begin
    dnum = '0;
    dden = {1'b0, sy_q};
    unique case (cmd_i.div_sel)
      zstp_pkg::DIV_ORGX: begin
        dnum = {5'd0, w_q, 9'd0};
        dden = {1'b0, sx_q};
      end
      zstp_pkg::DIV_ORGY: dnum = {5'd0, h_q, 9'd0};
      zstp_pkg::DIV_Y0: begin
        dnum = {3'd0, 1'b0, y_q, 11'd0} + {10'd0, sy_q};
        dden = {sy_q, 1'b0};
      end
      zstp_pkg::DIV_Y1: begin
        dnum = {3'd0, {1'b0, y_q} + 4'd1, 11'd0} + {10'd0, sy_q};
        dden = {sy_q, 1'b0};
      end
      zstp_pkg::DIV_X0: begin
        dnum = {3'd0, 1'b0, x_q, 11'd0} + {10'd0, sx_q};
        dden = {sx_q, 1'b0};
      end
      zstp_pkg::DIV_X1: begin
        dnum = {3'd0, {1'b0, x_q} + 4'd1, 11'd0} + {10'd0, sx_q};
        dden = {sx_q, 1'b0};
      end
      default: ;
    endcase
  end
  assign dstart = cmd_i.div_start;

  zstp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .num_i  (dnum),
    .den_i  (dden),
    .done_o (ddone),
    .quot_o (dq)
  );

  logic [9:0]  wmask;
  logic [10:0] ox_w, oy_w;
  logic signed [15:0] ox_wr, oy_wr;
  always_comb begin
    wmask = small_i ? 10'h1ff : 10'h3ff;
    ox_w  = {1'b0, (px_q - off_x_i[9:0]) & wmask};
    oy_w  = {1'b0, ((10'd0 - py_q) - off_y_i[9:0]) & wmask};
    ox_wr = 16'(ox_w);
    oy_wr = 16'(oy_w);
    if (ox_w >= (small_i ? 11'd448 : 11'd640)) ox_wr = ox_wr - (small_i ? 16'sd512 : 16'sd1024);
    if (oy_w >= (small_i ? 11'd384 : 11'd512)) oy_wr = oy_wr - (small_i ? 16'sd512 : 16'sd1024);
  end

  logic signed [15:0] q16;
  assign q16 = signed'(dq[15:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      attr_q  <= attribute_word_i;
      code_q  <= tile_code_i;
      color_q <= color_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      sy_q    <= scale_y_i;
      sx_q    <= sx_c;
      w_q     <= w_c;
      h_q     <= h_c;
    end
    if (cmd_i.take) begin
      unique case (cmd_i.div_sel)
        zstp_pkg::DIV_ORGX: ox_q <= ox_wr - q16 + 16'sd53 - 16'(shift_x_i);
        zstp_pkg::DIV_ORGY: oy_q <= oy_wr - q16 - 16'sd6 - 16'(shift_y_i);
        zstp_pkg::DIV_Y0:   y0_q <= oy_q + q16;
        zstp_pkg::DIV_Y1:   y1_q <= oy_q + q16;
        zstp_pkg::DIV_X0:   x0_q <= ox_q + q16;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.row_next) begin
      x_q <= '0;
    end else if (cmd_i.col_next) begin
      x_q <= x_q + 3'd1;
    end
    if (cmd_i.load) begin
      y_q <= '0;
    end else if (cmd_i.row_next) begin
      y_q <= y_q + 3'd1;
    end
  end

  logic [2:0]  xa, ya, ci, ri;
  logic [15:0] tile;
  logic signed [15:0] x1;
  always_comb begin
    xa = {code_q[4], code_q[2], code_q[0]};
    ya = {code_q[5], code_q[3], code_q[1]};
    ci = attr_q[12] ? (3'(w_q - 4'd1) - x_q + xa) : (x_q + xa);
    ri = attr_q[13] ? (3'(h_q - 4'd1) - y_q + ya) : (y_q + ya);
    if (w_q == 4'd1 && h_q == 4'd1) begin
      tile = code_q;
    end else begin
      tile = {code_q[15:6], 6'd0} + {8'd0, zstp_pkg::ColTable[ci]}
           + {8'd0, zstp_pkg::RowTable[ri]};
    end
    x1 = ox_q + q16;
  end

  logic valid_q;
  assign sts_o.out_busy = valid_q && !m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_o <= {2'd0, color_q[11:0], 4'd0, attr_q[13], attr_q[12],
                   11'(y1_q - y0_q), 11'(x1 - x0_q), y0_q[14:0], x0_q[14:0],
                   tile & mask_i};
      m_last_o <= sts_o.last_col && sts_o.last_row;
    end
  end

  logic unused;
  assign unused = ^{off_x_i[15:10], off_y_i[15:10], dq[17:16], attr_q[15:14],
                    attr_q[11:0], color_q[15:12]};
  assign m_valid_o = valid_q;
endmodule
`default_nettype wire

/* src/zstp_ctrl.sv */
// Controller: sequences origin divisions per sprite and edge divisions per row and sub-tile.
`default_nettype none
module zstp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  zstp_pkg::sts_t sts_i,
  output zstp_pkg::cmd_t cmd_o
);
  zstp_pkg::state_e state_q, state_d;
  logic started_q, started_d;

  always_comb begin
    state_d   = state_q;
    started_d = 1'b0;
    cmd_o     = '0;
    cmd_o.div_sel = zstp_pkg::DIV_ORGX;
    s_ready_o = 1'b0;
    unique case (state_q)
      zstp_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i && !sts_i.zero_scale) begin
          cmd_o.load = 1'b1;
          state_d    = zstp_pkg::ST_ORGX;
        end
      end
      zstp_pkg::ST_ORGX: begin
        cmd_o.div_sel = zstp_pkg::DIV_ORGX;
        cmd_o.div_start = !started_q;
        started_d = 1'b1;
        if (started_q && sts_i.div_done) begin
          cmd_o.take = 1'b1;
          started_d  = 1'b0;
          state_d    = zstp_pkg::ST_ORGY;
        end
      end
      zstp_pkg::ST_ORGY: begin
        cmd_o.div_sel = zstp_pkg::DIV_ORGY;
        cmd_o.div_start = !started_q;
        started_d = 1'b1;
        if (started_q && sts_i.div_done) begin
          cmd_o.take = 1'b1;
          started_d  = 1'b0;
          state_d    = zstp_pkg::ST_ROW;
        end
      end
      zstp_pkg::ST_ROW: begin
        // top edge of the row
        cmd_o.div_sel = zstp_pkg::DIV_Y0;
        cmd_o.div_start = !started_q;
        started_d = 1'b1;
        if (started_q && sts_i.div_done) begin
          cmd_o.take = 1'b1;
          started_d  = 1'b0;
          state_d    = zstp_pkg::ST_COL0;
        end
      end
      zstp_pkg::ST_COL0: begin
        cmd_o.div_sel = zstp_pkg::DIV_Y1;
        cmd_o.div_start = !started_q;
        started_d = 1'b1;
        if (started_q && sts_i.div_done) begin
          cmd_o.take = 1'b1;
          started_d  = 1'b0;
          state_d    = zstp_pkg::ST_COL1;
        end
      end
      zstp_pkg::ST_COL1: begin
        cmd_o.div_sel = zstp_pkg::DIV_X0;
        cmd_o.div_start = !started_q;
        started_d = 1'b1;
        if (started_q && sts_i.div_done) begin
          cmd_o.take = 1'b1;
          started_d  = 1'b0;
          state_d    = zstp_pkg::ST_EMIT;
        end
      end
      zstp_pkg::ST_EMIT: begin
        cmd_o.div_sel = zstp_pkg::DIV_X1;
        cmd_o.div_start = !started_q;
        started_d = 1'b1;
        if (started_q && !sts_i.out_busy && sts_i.div_done) begin
          cmd_o.emit = 1'b1;
          started_d  = 1'b0;
          if (!sts_i.last_col) begin
            cmd_o.col_next = 1'b1;
            state_d = zstp_pkg::ST_COL1;
          end else if (!sts_i.last_row) begin
            cmd_o.row_next = 1'b1;
            state_d = zstp_pkg::ST_ROW;
          end else begin
            state_d = zstp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = zstp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= zstp_pkg::ST_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
    end
  end
endmodule
`default_nettype wire

/* src/zstp_checker.sv */
// Port checker for the zoomed sprite tile placement unit, with its bind.
`default_nettype none
module zstp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic [87:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready mid sprite");
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[56:46] != 11'd0 && m_axis_tdata[67:57] != 11'd0)
    else $error("zero drawn size");
endmodule

bind zoomed_sprite_tile_placement_unit zstp_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
